FILE: rtl/row_display_line_map_unit_assert.svh
// ----------------------------------------------------------------------------
// row display line map assertion macros
// shared property wrappers clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef ROW_DISPLAY_LINE_MAP_UNIT_ASSERT_SVH
`define ROW_DISPLAY_LINE_MAP_UNIT_ASSERT_SVH

// checked outside reset only
`define RDLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define RDLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/rdlm_pkg.sv
// ----------------------------------------------------------------------------
// rdlm_pkg
// types and constants shared by the row display line map unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdlm_pkg;

  localparam int unsigned MAX_ROWS   = 1024;
  localparam int unsigned MAX_HEIGHT = 255;
  localparam int unsigned CNT_W      = $clog2(MAX_ROWS + 1);
  localparam int unsigned ADDR_W     = $clog2(MAX_ROWS);
  localparam int unsigned HGT_W      = 8;
  localparam int unsigned LINE_W     = 18;
  localparam int unsigned SUB_W      = 8;
  localparam int unsigned OP_W       = 4;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [HGT_W-1:0]  hgt_t;

  typedef struct packed {
    hgt_t height;
    logic shown;
    logic open;
  } row_entry_t;

  typedef struct packed {
    logic       we;
    addr_t      waddr;
    row_entry_t wdata;
    addr_t      raddr;
  } row_req_t;

  typedef struct packed {
    logic  we;
    cnt_t  waddr;
    line_t wdata;
    cnt_t  raddr;
  } ds_req_t;

  typedef enum logic [OP_W-1:0] {
    OP_RESET         = 4'd0,
    OP_INSERT        = 4'd1,
    OP_REMOVE        = 4'd2,
    OP_SET_HEIGHT    = 4'd3,
    OP_SET_VISIBLE   = 4'd4,
    OP_SET_EXPANDED  = 4'd5,
    OP_SHOW_ALL      = 4'd6,
    OP_FORGET        = 4'd7,
    OP_QUERY_ROW     = 4'd8,
    OP_DISP_FIRST    = 4'd9,
    OP_DISP_LAST     = 4'd10,
    OP_ROW_FROM_LINE = 4'd11,
    OP_CONTR_NEXT    = 4'd12,
    OP_NEXT_VIS      = 4'd13,
    OP_PREV_VIS      = 4'd14
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_FILL, S_CP_RD, S_CP_WR, S_MOD_RD, S_MOD_WR,
    S_RB_INIT, S_RB_LD, S_RB_RD, S_RB_WR,
    S_DS_RD, S_Q_DS, S_ROW_RD, S_Q_ROW,
    S_BS, S_BS_CK, S_BS_ROW, S_BS_VIS,
    S_SC_RD, S_SC_CK, S_SUB_RD, S_SUB, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    POST_RESULT, POST_LINE0, POST_PAST, POST_MID
  } post_e;

endpackage

FILE: rtl/rdlm_tables.sv
// ----------------------------------------------------------------------------
// rdlm_tables
// row table and display start table, one write and one read port each
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdlm_tables (
  input  logic                clk_i,
  input  rdlm_pkg::row_req_t  row_req_i,
  output rdlm_pkg::row_entry_t row_rdata_o,
  input  rdlm_pkg::ds_req_t   ds_req_i,
  output rdlm_pkg::line_t     ds_rdata_o
);

  rdlm_pkg::row_entry_t row_mem [rdlm_pkg::MAX_ROWS];
  rdlm_pkg::line_t      ds_mem  [rdlm_pkg::MAX_ROWS + 1];

  rdlm_pkg::row_entry_t row_rd_q;
  rdlm_pkg::line_t      ds_rd_q;
  logic                 ds_zero_q;

  always_ff @(posedge clk_i) begin
    if (row_req_i.we) begin
      row_mem[row_req_i.waddr] <= row_req_i.wdata;
    end
    row_rd_q <= row_mem[row_req_i.raddr];
  end

  // entry zero is never written: the first row always starts at line zero
  always_ff @(posedge clk_i) begin
    if (ds_req_i.we) begin
      ds_mem[ds_req_i.waddr] <= ds_req_i.wdata;
    end
    ds_rd_q   <= ds_mem[ds_req_i.raddr];
    ds_zero_q <= (ds_req_i.raddr == '0);
  end

  assign row_rdata_o = row_rd_q;
  assign ds_rdata_o  = ds_zero_q ? '0 : ds_rd_q;

endmodule

FILE: rtl/row_display_line_map_unit.sv
// ----------------------------------------------------------------------------
// row_display_line_map_unit
// fold and wrap line map: document rows to display lines and back
// ----------------------------------------------------------------------------
// usage
// - command channel: a transaction is taken at a rising edge with start_i high
//   and busy_o low; op_i selects the command, the other fields are its operands
// - result channel: done_o is high for exactly one cycle with the result
//   fields; one result per command, and the receiver cannot hold it off
// - latency depends on the command; the row table has a single read port, so
//   each row step takes a read state and then a write state
//   * row from display: a binary search over the line starts plus a visible scan
//   * visible / contracted searches: a read and a check per row inspected
//   * edits: a read and a write per row touched or moved, a write per inserted
//     row, then a prefix rebuild from the first changed row to the end
//   * worst case: an edit or a search over a full table
// - busy_o stays high from the accepting edge through the done_o cycle
// - reset empties the table at once (row count zero); no clearing pass runs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "row_display_line_map_unit_assert.svh"

module row_display_line_map_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [rdlm_pkg::OP_W-1:0] op_i,
  input  rdlm_pkg::cnt_t            row_i,
  input  rdlm_pkg::cnt_t            row_end_i,
  input  rdlm_pkg::cnt_t            count_i,
  input  rdlm_pkg::hgt_t            value_i,
  input  rdlm_pkg::line_t           line_i,
  output logic                      done_o,
  output rdlm_pkg::line_t           result_value_o,
  output logic                      found_o,
  output logic                      changed_o,
  output logic [rdlm_pkg::SUB_W-1:0] sub_line_o,
  output logic                      row_visible_o,
  output logic                      row_expanded_o,
  output logic                      overflow_o
);

  localparam rdlm_pkg::cnt_t MaxRowsC   = rdlm_pkg::cnt_t'(rdlm_pkg::MAX_ROWS);
  localparam rdlm_pkg::hgt_t MaxHeightC = rdlm_pkg::hgt_t'(rdlm_pkg::MAX_HEIGHT);

  // sequencer and loop registers
  rdlm_pkg::state_e state_q, state_d;
  rdlm_pkg::cnt_t   n_q, n_d;          // row count
  rdlm_pkg::op_e    op_q, op_d;
  rdlm_pkg::cnt_t   row_q, row_d;
  rdlm_pkg::cnt_t   cnt_q, cnt_d;
  rdlm_pkg::hgt_t   val_q, val_d;
  rdlm_pkg::line_t  line_q, line_d;
  rdlm_pkg::cnt_t   idx_q, idx_d;      // walking index
  rdlm_pkg::cnt_t   end_q, end_d;      // walk bound
  rdlm_pkg::cnt_t   rb_q, rb_d;        // prefix rebuild start
  rdlm_pkg::cnt_t   lo_q, lo_d;
  rdlm_pkg::cnt_t   hi_q, hi_d;
  rdlm_pkg::line_t  acc_q, acc_d;      // running display line
  logic             fwd_q, fwd_d;      // scan direction
  logic             ph2_q, ph2_d;      // second scan leg pending
  rdlm_pkg::cnt_t   p2s_q, p2s_d;
  logic             p2f_q, p2f_d;
  rdlm_pkg::post_e  post_q, post_d;

  // result registers
  rdlm_pkg::line_t  res_q, res_d;
  logic             found_q, found_d;
  logic             chg_q, chg_d;
  rdlm_pkg::hgt_t   sub_q, sub_d;
  logic             vis_q, vis_d;
  logic             exp_q, exp_d;
  logic             ovf_q, ovf_d;

  rdlm_pkg::row_req_t   row_req;
  rdlm_pkg::ds_req_t    ds_req;
  rdlm_pkg::row_entry_t row_rd;
  rdlm_pkg::line_t      ds_rd;

  rdlm_tables u_tables (
    .clk_i      (clk_i),
    .row_req_i  (row_req),
    .row_rdata_o(row_rd),
    .ds_req_i   (ds_req),
    .ds_rdata_o (ds_rd)
  );

  // operand clamps for the dispatch cycle
  rdlm_pkg::cnt_t n_m1, row_cl, row_last, free_rows, ins_c, rem_left, rem_c, rst_rows, vis_end;
  assign n_m1      = n_q - 1'b1;
  assign row_cl    = (row_i > n_q) ? n_q : row_i;
  assign row_last  = (row_i > n_m1) ? n_m1 : row_i;
  assign free_rows = MaxRowsC - n_q;
  assign ins_c     = (count_i > free_rows) ? free_rows : count_i;
  assign rem_left  = n_q - row_cl;
  assign rem_c     = (count_i > rem_left) ? rem_left : count_i;
  assign rst_rows  = (row_i > MaxRowsC) ? MaxRowsC : row_i;
  assign vis_end   = (row_end_i > n_m1) ? n_m1 : row_end_i;

  // binary search midpoint
  logic [rdlm_pkg::CNT_W:0] mid_sum;
  rdlm_pkg::cnt_t           mid;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
  assign mid     = mid_sum[rdlm_pkg::CNT_W:1];

  // row rewrite for the edit walk
  rdlm_pkg::hgt_t       hsat;
  rdlm_pkg::row_entry_t mod_new;
  logic                 mod_chg;
  assign hsat = (val_q > MaxHeightC) ? MaxHeightC : val_q;

  always_comb begin
    mod_new = row_rd;
    mod_chg = 1'b0;
    case (op_q)
      rdlm_pkg::OP_SET_HEIGHT: begin
        mod_new.height = hsat;
        mod_chg        = (row_rd.height != hsat) && row_rd.shown;
      end
      rdlm_pkg::OP_SET_VISIBLE: begin
        mod_new.shown = val_q[0];
        mod_chg       = (row_rd.shown != val_q[0]);
      end
      rdlm_pkg::OP_SET_EXPANDED: begin
        mod_new.open = val_q[0];
        mod_chg      = (row_rd.open != val_q[0]);
      end
      rdlm_pkg::OP_SHOW_ALL: begin
        mod_new.shown = 1'b1;
        mod_new.open  = 1'b1;
        mod_chg       = !row_rd.shown;
      end
      rdlm_pkg::OP_FORGET: begin
        mod_new.height = rdlm_pkg::hgt_t'(1);
      end
      default: begin
        mod_new = row_rd;
      end
    endcase
  end

  // prefix step and scan test
  rdlm_pkg::line_t rb_sum;
  logic            scan_hit;
  assign rb_sum   = acc_q + (row_rd.shown ? rdlm_pkg::line_t'(row_rd.height) : '0);
  assign scan_hit = (op_q == rdlm_pkg::OP_CONTR_NEXT) ? !row_rd.open : row_rd.shown;

  // next state and datapath
  always_comb begin
    logic scan_end;
    logic scan_fail;
    logic scan_found;
    state_d  = state_q;
    n_d      = n_q;
    op_d     = op_q;
    row_d    = row_q;
    cnt_d    = cnt_q;
    val_d    = val_q;
    line_d   = line_q;
    idx_d    = idx_q;
    end_d    = end_q;
    rb_d     = rb_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    acc_d    = acc_q;
    fwd_d    = fwd_q;
    ph2_d    = ph2_q;
    p2s_d    = p2s_q;
    p2f_d    = p2f_q;
    post_d   = post_q;
    res_d    = res_q;
    found_d  = found_q;
    chg_d    = chg_q;
    sub_d    = sub_q;
    vis_d    = vis_q;
    exp_d    = exp_q;
    ovf_d    = ovf_q;
    scan_end   = 1'b0;
    scan_fail  = 1'b0;
    scan_found = 1'b0;

    case (state_q)
      rdlm_pkg::S_IDLE: begin
        if (start_i) begin
          op_d    = rdlm_pkg::op_e'(op_i);
          row_d   = row_i;
          cnt_d   = count_i;
          val_d   = value_i;
          line_d  = line_i;
          res_d   = '0;
          found_d = 1'b0;
          chg_d   = 1'b0;
          sub_d   = '0;
          vis_d   = 1'b0;
          exp_d   = 1'b0;
          ovf_d   = 1'b0;
          ph2_d   = 1'b0;
          post_d  = rdlm_pkg::POST_RESULT;
          state_d = rdlm_pkg::S_DONE;
          case (rdlm_pkg::op_e'(op_i))
            rdlm_pkg::OP_RESET: begin
              n_d     = rst_rows;
              ovf_d   = (row_i > MaxRowsC);
              res_d   = rdlm_pkg::line_t'(rst_rows);
              idx_d   = '0;
              end_d   = rst_rows;
              rb_d    = '0;
              state_d = rdlm_pkg::S_FILL;
            end
            rdlm_pkg::OP_INSERT: begin
              ovf_d = (count_i > free_rows);
              res_d = rdlm_pkg::line_t'(n_q);
              if (ins_c != '0) begin
                row_d   = row_cl;
                cnt_d   = ins_c;
                n_d     = n_q + ins_c;
                res_d   = rdlm_pkg::line_t'(n_q + ins_c);
                idx_d   = n_q;
                rb_d    = row_cl;
                state_d = rdlm_pkg::S_CP_RD;
              end
            end
            rdlm_pkg::OP_REMOVE: begin
              res_d = rdlm_pkg::line_t'(n_q);
              if (rem_c != '0) begin
                row_d   = row_cl;
                cnt_d   = rem_c;
                n_d     = n_q - rem_c;
                res_d   = rdlm_pkg::line_t'(n_q - rem_c);
                idx_d   = row_cl;
                end_d   = n_q - rem_c;
                rb_d    = row_cl;
                state_d = rdlm_pkg::S_CP_RD;
              end
            end
            rdlm_pkg::OP_SET_HEIGHT, rdlm_pkg::OP_SET_EXPANDED: begin
              if (row_i < n_q && (op_i != rdlm_pkg::OP_SET_HEIGHT || value_i != '0)) begin
                idx_d   = row_i;
                end_d   = row_i;
                rb_d    = row_i;
                state_d = rdlm_pkg::S_MOD_RD;
              end
            end
            rdlm_pkg::OP_SET_VISIBLE: begin
              if (n_q != '0 && row_i <= vis_end) begin
                idx_d   = row_i;
                end_d   = vis_end;
                rb_d    = row_i;
                state_d = rdlm_pkg::S_MOD_RD;
              end
            end
            rdlm_pkg::OP_SHOW_ALL, rdlm_pkg::OP_FORGET: begin
              if (n_q != '0) begin
                idx_d   = '0;
                end_d   = n_m1;
                rb_d    = '0;
                state_d = rdlm_pkg::S_MOD_RD;
              end
            end
            rdlm_pkg::OP_QUERY_ROW: begin
              if (row_i < n_q) begin
                idx_d   = row_i;
                state_d = rdlm_pkg::S_ROW_RD;
              end else begin
                res_d = rdlm_pkg::line_t'(1);
                exp_d = 1'b1;
              end
            end
            rdlm_pkg::OP_DISP_FIRST, rdlm_pkg::OP_DISP_LAST: begin
              if (n_q != '0) begin
                idx_d   = row_cl;
                state_d = rdlm_pkg::S_DS_RD;
              end
            end
            rdlm_pkg::OP_ROW_FROM_LINE: begin
              if (n_q != '0) begin
                idx_d   = n_q;
                state_d = rdlm_pkg::S_DS_RD;
              end
            end
            rdlm_pkg::OP_CONTR_NEXT: begin
              idx_d   = row_i;
              fwd_d   = 1'b1;
              state_d = rdlm_pkg::S_SC_RD;
            end
            rdlm_pkg::OP_NEXT_VIS: begin
              if (n_q != '0) begin
                idx_d   = row_i;
                fwd_d   = 1'b1;
                ph2_d   = 1'b1;
                p2s_d   = row_last;
                p2f_d   = 1'b0;
                state_d = rdlm_pkg::S_SC_RD;
              end
            end
            rdlm_pkg::OP_PREV_VIS: begin
              if (n_q != '0) begin
                idx_d   = row_last;
                fwd_d   = 1'b0;
                ph2_d   = 1'b1;
                p2s_d   = '0;
                p2f_d   = 1'b1;
                state_d = rdlm_pkg::S_SC_RD;
              end
            end
            default: begin
              state_d = rdlm_pkg::S_DONE;
            end
          endcase
        end
      end

      // new rows: height one, shown, expanded
      rdlm_pkg::S_FILL: begin
        if (idx_q < end_q) begin
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = rdlm_pkg::S_RB_INIT;
        end
      end

      // row moves: insert walks down, remove walks up
      rdlm_pkg::S_CP_RD: begin
        if (op_q == rdlm_pkg::OP_INSERT) begin
          if (idx_q > row_q) begin
            state_d = rdlm_pkg::S_CP_WR;
          end else begin
            idx_d   = row_q;
            end_d   = row_q + cnt_q;
            state_d = rdlm_pkg::S_FILL;
          end
        end else begin
          if (idx_q < end_q) begin
            state_d = rdlm_pkg::S_CP_WR;
          end else begin
            state_d = rdlm_pkg::S_RB_INIT;
          end
        end
      end
      rdlm_pkg::S_CP_WR: begin
        idx_d   = (op_q == rdlm_pkg::OP_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
        state_d = rdlm_pkg::S_CP_RD;
      end

      rdlm_pkg::S_MOD_RD: begin
        state_d = rdlm_pkg::S_MOD_WR;
      end
      rdlm_pkg::S_MOD_WR: begin
        chg_d = chg_q | mod_chg;
        if (idx_q == end_q) begin
          state_d = (op_q == rdlm_pkg::OP_SET_EXPANDED) ? rdlm_pkg::S_DONE
                                                          : rdlm_pkg::S_RB_INIT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = rdlm_pkg::S_MOD_RD;
        end
      end

      // prefix rebuild from rb_q to the row count
      rdlm_pkg::S_RB_INIT: begin
        idx_d   = rb_q;
        state_d = rdlm_pkg::S_RB_LD;
      end
      rdlm_pkg::S_RB_LD: begin
        acc_d   = ds_rd;
        state_d = rdlm_pkg::S_RB_RD;
      end
      rdlm_pkg::S_RB_RD: begin
        state_d = (idx_q < n_q) ? rdlm_pkg::S_RB_WR : rdlm_pkg::S_DONE;
      end
      rdlm_pkg::S_RB_WR: begin
        acc_d   = rb_sum;
        idx_d   = idx_q + 1'b1;
        state_d = rdlm_pkg::S_RB_RD;
      end

      rdlm_pkg::S_DS_RD: begin
        state_d = rdlm_pkg::S_Q_DS;
      end
      rdlm_pkg::S_Q_DS: begin
        acc_d = ds_rd;
        if (op_q == rdlm_pkg::OP_DISP_LAST && row_q < n_q) begin
          idx_d   = row_q;
          state_d = rdlm_pkg::S_ROW_RD;
        end else if (op_q == rdlm_pkg::OP_ROW_FROM_LINE) begin
          if (line_q == '0) begin
            idx_d   = '0;
            fwd_d   = 1'b1;
            ph2_d   = 1'b1;
            p2s_d   = '0;
            p2f_d   = 1'b0;
            post_d  = rdlm_pkg::POST_LINE0;
            state_d = rdlm_pkg::S_SC_RD;
          end else if (line_q >= ds_rd) begin
            idx_d   = n_m1;
            fwd_d   = 1'b0;
            ph2_d   = 1'b1;
            p2s_d   = '0;
            p2f_d   = 1'b1;
            post_d  = rdlm_pkg::POST_PAST;
            state_d = rdlm_pkg::S_SC_RD;
          end else begin
            lo_d    = '0;
            hi_d    = n_q;
            state_d = rdlm_pkg::S_BS;
          end
        end else begin
          res_d   = ds_rd;
          state_d = rdlm_pkg::S_DONE;
        end
      end

      rdlm_pkg::S_ROW_RD: begin
        state_d = rdlm_pkg::S_Q_ROW;
      end
      rdlm_pkg::S_Q_ROW: begin
        state_d = rdlm_pkg::S_DONE;
        case (op_q)
          rdlm_pkg::OP_QUERY_ROW: begin
            found_d = 1'b1;
            res_d   = rdlm_pkg::line_t'(row_rd.height);
            vis_d   = row_rd.shown;
            exp_d   = row_rd.open;
          end
          rdlm_pkg::OP_DISP_LAST: begin
            res_d = row_rd.shown ? acc_q + rdlm_pkg::line_t'(row_rd.height - 1'b1) : acc_q;
          end
          default: begin
            found_d = 1'b1;
            res_d   = rdlm_pkg::line_t'(idx_q);
            sub_d   = row_rd.height - 1'b1;
          end
        endcase
      end

      // binary search for the last start at or below the line
      rdlm_pkg::S_BS: begin
        if (lo_q < hi_q) begin
          idx_d   = mid;
          state_d = rdlm_pkg::S_BS_CK;
        end else begin
          lo_d    = (lo_q > n_m1) ? n_m1 : lo_q;
          state_d = rdlm_pkg::S_BS_ROW;
        end
      end
      rdlm_pkg::S_BS_CK: begin
        if (line_q < ds_rd) begin
          hi_d = idx_q - 1'b1;
        end else begin
          lo_d = idx_q;
        end
        state_d = rdlm_pkg::S_BS;
      end
      rdlm_pkg::S_BS_ROW: begin
        state_d = rdlm_pkg::S_BS_VIS;
      end
      rdlm_pkg::S_BS_VIS: begin
        if (row_rd.shown) begin
          state_d = rdlm_pkg::S_SUB_RD;
        end else begin
          idx_d   = lo_q;
          fwd_d   = 1'b1;
          ph2_d   = 1'b1;
          p2s_d   = lo_q;
          p2f_d   = 1'b0;
          post_d  = rdlm_pkg::POST_MID;
          state_d = rdlm_pkg::S_SC_RD;
        end
      end

      // row scan, optionally followed by a second leg
      rdlm_pkg::S_SC_RD: begin
        if (fwd_q && idx_q >= n_q) begin
          scan_fail = 1'b1;
        end else begin
          state_d = rdlm_pkg::S_SC_CK;
        end
      end
      rdlm_pkg::S_SC_CK: begin
        if (scan_hit) begin
          scan_end   = 1'b1;
          scan_found = 1'b1;
        end else if ((fwd_q && idx_q == n_m1) || (!fwd_q && idx_q == '0)) begin
          scan_fail = 1'b1;
        end else begin
          idx_d   = fwd_q ? idx_q + 1'b1 : idx_q - 1'b1;
          state_d = rdlm_pkg::S_SC_RD;
        end
      end

      rdlm_pkg::S_SUB_RD: begin
        state_d = rdlm_pkg::S_SUB;
      end
      rdlm_pkg::S_SUB: begin
        rdlm_pkg::line_t diff;
        diff    = line_q - ds_rd;
        found_d = 1'b1;
        res_d   = rdlm_pkg::line_t'(lo_q);
        sub_d   = (line_q > ds_rd) ? diff[rdlm_pkg::HGT_W-1:0] : '0;
        state_d = rdlm_pkg::S_DONE;
      end

      rdlm_pkg::S_DONE: begin
        state_d = rdlm_pkg::S_IDLE;
      end

      default: begin
        state_d = rdlm_pkg::S_IDLE;
      end
    endcase

    if (scan_fail) begin
      if (ph2_q) begin
        idx_d   = p2s_q;
        fwd_d   = p2f_q;
        ph2_d   = 1'b0;
        state_d = rdlm_pkg::S_SC_RD;
      end else begin
        scan_end = 1'b1;
      end
    end

    if (scan_end) begin
      case (post_q)
        rdlm_pkg::POST_RESULT: begin
          found_d = scan_found;
          res_d   = scan_found ? rdlm_pkg::line_t'(idx_q) : '0;
          state_d = rdlm_pkg::S_DONE;
        end
        rdlm_pkg::POST_LINE0: begin
          found_d = 1'b1;
          res_d   = scan_found ? rdlm_pkg::line_t'(idx_q) : '0;
          state_d = rdlm_pkg::S_DONE;
        end
        rdlm_pkg::POST_PAST: begin
          idx_d   = scan_found ? idx_q : n_m1;
          state_d = rdlm_pkg::S_ROW_RD;
        end
        default: begin
          lo_d    = scan_found ? idx_q : lo_q;
          state_d = rdlm_pkg::S_SUB_RD;
        end
      endcase
    end
  end

  // table ports and handshake
  always_comb begin
    row_req       = '0;
    ds_req        = '0;
    row_req.raddr = idx_q[rdlm_pkg::ADDR_W-1:0];
    ds_req.raddr  = idx_q;
    case (state_q)
      rdlm_pkg::S_FILL: begin
        row_req.we    = (idx_q < end_q);
        row_req.waddr = idx_q[rdlm_pkg::ADDR_W-1:0];
        row_req.wdata = '{height: rdlm_pkg::hgt_t'(1), shown: 1'b1, open: 1'b1};
      end
      rdlm_pkg::S_CP_RD: begin
        if (op_q == rdlm_pkg::OP_INSERT) begin
          row_req.raddr = rdlm_pkg::addr_t'(idx_q - 1'b1);
        end else begin
          row_req.raddr = rdlm_pkg::addr_t'(idx_q + cnt_q);
        end
      end
      rdlm_pkg::S_CP_WR: begin
        row_req.we    = 1'b1;
        row_req.wdata = row_rd;
        if (op_q == rdlm_pkg::OP_INSERT) begin
          row_req.waddr = rdlm_pkg::addr_t'(idx_q - 1'b1 + cnt_q);
        end else begin
          row_req.waddr = idx_q[rdlm_pkg::ADDR_W-1:0];
        end
      end
      rdlm_pkg::S_MOD_WR: begin
        row_req.we    = 1'b1;
        row_req.waddr = idx_q[rdlm_pkg::ADDR_W-1:0];
        row_req.wdata = mod_new;
      end
      rdlm_pkg::S_RB_INIT: begin
        ds_req.raddr = rb_q;
      end
      rdlm_pkg::S_RB_WR: begin
        ds_req.we    = 1'b1;
        ds_req.waddr = idx_q + 1'b1;
        ds_req.wdata = rb_sum;
      end
      rdlm_pkg::S_BS: begin
        ds_req.raddr = mid;
      end
      rdlm_pkg::S_BS_ROW: begin
        row_req.raddr = lo_q[rdlm_pkg::ADDR_W-1:0];
      end
      rdlm_pkg::S_SUB_RD: begin
        ds_req.raddr = lo_q;
      end
      default: begin
        row_req.we = 1'b0;
      end
    endcase
  end

  assign busy_o         = (state_q != rdlm_pkg::S_IDLE);
  assign done_o         = (state_q == rdlm_pkg::S_DONE);
  assign result_value_o = res_q;
  assign found_o        = found_q;
  assign changed_o      = chg_q;
  assign sub_line_o     = sub_q;
  assign row_visible_o  = vis_q;
  assign row_expanded_o = exp_q;
  assign overflow_o     = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdlm_pkg::S_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    row_q   <= row_d;
    cnt_q   <= cnt_d;
    val_q   <= val_d;
    line_q  <= line_d;
    idx_q   <= idx_d;
    end_q   <= end_d;
    rb_q    <= rb_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    acc_q   <= acc_d;
    fwd_q   <= fwd_d;
    ph2_q   <= ph2_d;
    p2s_q   <= p2s_d;
    p2f_q   <= p2f_d;
    post_q  <= post_d;
    res_q   <= res_d;
    found_q <= found_d;
    chg_q   <= chg_d;
    sub_q   <= sub_d;
    vis_q   <= vis_d;
    exp_q   <= exp_d;
    ovf_q   <= ovf_d;
  end

  `RDLM_ASSERT(a_done_in_txn, done_o |-> busy_o, "result strobe outside a transaction")
  `RDLM_ASSERT(a_done_pulse, done_o |=> !done_o, "result strobe longer than one cycle")
  `RDLM_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "command taken but not busy")
  `RDLM_ASSERT(a_rows_bound, n_q <= MaxRowsC, "row count past table size")

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the row display line map unit: a local model of the
// row table predicts each command's result, a queue of expected results is
// checked against every done strobe, directed commands then random traffic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef logic [rdlm_pkg::OP_W-1:0] op_t;

  localparam int NUM_ITEMS = 580;
  localparam int CALM_TAIL = 60;          // last transactions run with no idling
  localparam int WDOG_LIMIT = 40000;      // watchdog limit, above the longest command
  localparam op_t OP_UNUSED = 4'd15;

  typedef struct {
    op_t             op;
    rdlm_pkg::cnt_t  row;
    rdlm_pkg::cnt_t  row_end;
    rdlm_pkg::cnt_t  count;
    rdlm_pkg::hgt_t  value;
    rdlm_pkg::line_t line;
  } cmd_t;

  typedef struct {
    rdlm_pkg::line_t result_value;
    logic            found;
    logic            changed;
    logic [7:0]      sub_line;
    logic            row_visible;
    logic            row_expanded;
    logic            overflow;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  op_t op_i = '0;
  rdlm_pkg::cnt_t row_i = '0;
  rdlm_pkg::cnt_t row_end_i = '0;
  rdlm_pkg::cnt_t count_i = '0;
  rdlm_pkg::hgt_t value_i = '0;
  rdlm_pkg::line_t line_i = '0;
  logic done_o;
  rdlm_pkg::line_t result_value_o;
  logic found_o, changed_o, row_visible_o, row_expanded_o, overflow_o;
  logic [rdlm_pkg::SUB_W-1:0] sub_line_o;

  row_display_line_map_unit i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .row_i, .row_end_i, .count_i,
    .value_i, .line_i, .done_o, .result_value_o, .found_o, .changed_o,
    .sub_line_o, .row_visible_o, .row_expanded_o, .overflow_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // shadow row table
  // --------------------------------------------------------------------------
  int unsigned row_count;
  int unsigned height_tbl [rdlm_pkg::MAX_ROWS];
  bit          shown_tbl  [rdlm_pkg::MAX_ROWS];
  bit          open_tbl   [rdlm_pkg::MAX_ROWS];
  int unsigned line_start [rdlm_pkg::MAX_ROWS+1];

  cmd_t    cmd_q [$];       // commands waiting for the driver
  answer_t answer_q [$];    // predicted results in command order
  bit      failed = 1'b0;
  bit      idle_ok = 1'b1;
  bit      taken = 1'b0;    // a transaction was accepted at the last rising edge
  int      gap = 0;

  function automatic void clear_table();
    for (int i = 0; i < rdlm_pkg::MAX_ROWS; i++) begin
      height_tbl[i] = 1;
      shown_tbl[i] = 1'b1;
      open_tbl[i] = 1'b1;
    end
    for (int i = 0; i <= rdlm_pkg::MAX_ROWS; i++) line_start[i] = i;
  endfunction

  // prefix sums from one row to the end
  function automatic void refresh_starts(int unsigned from);
    for (int unsigned i = from; i < row_count; i++)
      line_start[i+1] = line_start[i] + (shown_tbl[i] ? height_tbl[i] : 0);
  endfunction

  function automatic int seek_shown_fwd(int r);
    if (row_count == 0) return -1;
    if (r < 0) r = 0;
    for (int i = r; i < int'(row_count); i++)
      if (shown_tbl[i]) return i;
    // nothing visible further on: look back instead
    if (r > int'(row_count) - 1) r = int'(row_count) - 1;
    for (int i = r; i >= 0; i--)
      if (shown_tbl[i]) return i;
    return -1;
  endfunction

  function automatic int seek_shown_back(int r);
    if (row_count == 0) return -1;
    if (r > int'(row_count) - 1) r = int'(row_count) - 1;
    for (int i = r; i >= 0; i--)
      if (shown_tbl[i]) return i;
    return seek_shown_fwd(0);
  endfunction

  function automatic bit show_range(int unsigned a, int unsigned b, bit vis);
    bit moved = 1'b0;
    if (row_count == 0) return 1'b0;
    if (b > row_count - 1) b = row_count - 1;
    if (a > b) return 1'b0;
    for (int unsigned i = a; i <= b; i++)
      if (shown_tbl[i] != vis) begin
        shown_tbl[i] = vis;
        moved = 1'b1;
      end
    if (moved) refresh_starts(a);
    return moved;
  endfunction

  // applies one command to the shadow table and returns its result
  function automatic answer_t apply_command(cmd_t c);
    answer_t a = '{default: '0};
    int unsigned n = row_count;
    int unsigned row = c.row;
    int unsigned cnt = c.count;
    int unsigned ln = c.line;
    int unsigned val = c.value;
    int unsigned res = 0, sub = 0, base, removed, total, lo, hi, mid, p;
    int r;
    case (c.op)
      rdlm_pkg::OP_RESET: begin
        if (row > rdlm_pkg::MAX_ROWS) begin
          row = rdlm_pkg::MAX_ROWS;
          a.overflow = 1'b1;
        end
        row_count = row;
        clear_table();
        res = row_count;
      end
      rdlm_pkg::OP_INSERT: begin
        if (row > n) row = n;
        if (cnt > rdlm_pkg::MAX_ROWS - n) begin
          cnt = rdlm_pkg::MAX_ROWS - n;
          a.overflow = 1'b1;
        end
        if (cnt > 0) begin
          base = line_start[row];
          for (int unsigned i = n; i > row; i--) begin
            height_tbl[i-1+cnt] = height_tbl[i-1];
            shown_tbl[i-1+cnt] = shown_tbl[i-1];
            open_tbl[i-1+cnt] = open_tbl[i-1];
          end
          for (int unsigned i = n + 1; i > row; i--)
            line_start[i-1+cnt] = line_start[i-1] + cnt;
          for (int unsigned i = 0; i < cnt; i++) begin
            height_tbl[row+i] = 1;
            shown_tbl[row+i] = 1'b1;
            open_tbl[row+i] = 1'b1;
            line_start[row+i] = base + i;
          end
          row_count = n + cnt;
        end
        res = row_count;
      end
      rdlm_pkg::OP_REMOVE: begin
        if (row > n) row = n;
        if (cnt > n - row) cnt = n - row;
        if (cnt > 0) begin
          removed = line_start[row+cnt] - line_start[row];
          for (int unsigned i = row; i + cnt < n; i++) begin
            height_tbl[i] = height_tbl[i+cnt];
            shown_tbl[i] = shown_tbl[i+cnt];
            open_tbl[i] = open_tbl[i+cnt];
          end
          for (int unsigned i = row; i + cnt <= n; i++)
            line_start[i] = line_start[i+cnt] - removed;
          row_count = n - cnt;
        end
        res = row_count;
      end
      rdlm_pkg::OP_SET_HEIGHT: begin
        if (row < n && val >= 1) begin
          if (val > rdlm_pkg::MAX_HEIGHT) val = rdlm_pkg::MAX_HEIGHT;
          if (height_tbl[row] != val) begin
            height_tbl[row] = val;
            // a hidden row keeps its new height but the map does not move
            if (shown_tbl[row]) begin
              refresh_starts(row);
              a.changed = 1'b1;
            end
          end
        end
      end
      rdlm_pkg::OP_SET_VISIBLE: a.changed = show_range(row, c.row_end, c.value[0]);
      rdlm_pkg::OP_SET_EXPANDED: begin
        if (row < n && open_tbl[row] != c.value[0]) begin
          open_tbl[row] = c.value[0];
          a.changed = 1'b1;
        end
      end
      rdlm_pkg::OP_SHOW_ALL: begin
        if (n > 0) a.changed = show_range(0, n - 1, 1'b1);
        for (int i = 0; i < rdlm_pkg::MAX_ROWS; i++) open_tbl[i] = 1'b1;
      end
      rdlm_pkg::OP_FORGET: begin
        for (int unsigned i = 0; i < n; i++) height_tbl[i] = 1;
        refresh_starts(0);
      end
      rdlm_pkg::OP_QUERY_ROW: begin
        if (row < n) begin
          a.found = 1'b1;
          res = height_tbl[row];
          a.row_visible = shown_tbl[row];
          a.row_expanded = open_tbl[row];
        end else begin
          res = 1;
          a.row_expanded = 1'b1;
        end
      end
      rdlm_pkg::OP_DISP_FIRST, rdlm_pkg::OP_DISP_LAST: begin
        if (n > 0) begin
          p = row > n ? n : row;
          res = line_start[p];
          if (c.op == rdlm_pkg::OP_DISP_LAST && row < n && shown_tbl[row])
            res = res + height_tbl[row] - 1;
        end
      end
      rdlm_pkg::OP_ROW_FROM_LINE: begin
        if (n > 0) begin
          total = line_start[n];
          a.found = 1'b1;
          if (ln == 0) begin
            r = seek_shown_fwd(0);
            res = r < 0 ? 0 : r;
          end else if (ln >= total) begin
            // past the end: last visible row, its last sub-line
            r = seek_shown_back(int'(n) - 1);
            p = r < 0 ? n - 1 : r;
            res = p;
            sub = height_tbl[p] - 1;
          end else begin
            lo = 0;
            hi = n;
            while (lo < hi) begin
              mid = (lo + hi + 1) / 2;
              if (ln < line_start[mid]) hi = mid - 1;
              else lo = mid;
            end
            if (lo > n - 1) lo = n - 1;
            if (!shown_tbl[lo]) begin
              r = seek_shown_fwd(lo);
              if (r >= 0) lo = r;
            end
            res = lo;
            sub = ln > line_start[lo] ? ln - line_start[lo] : 0;
          end
        end
      end
      rdlm_pkg::OP_CONTR_NEXT: begin
        for (int unsigned i = row; i < n; i++)
          if (!open_tbl[i]) begin
            a.found = 1'b1;
            res = i;
            break;
          end
      end
      rdlm_pkg::OP_NEXT_VIS, rdlm_pkg::OP_PREV_VIS: begin
        r = c.op == rdlm_pkg::OP_NEXT_VIS ? seek_shown_fwd(row) : seek_shown_back(row);
        if (r >= 0) begin
          a.found = 1'b1;
          res = r;
        end
      end
      default: ;
    endcase
    a.result_value = res[rdlm_pkg::LINE_W-1:0];
    a.sub_line = sub[7:0];
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic cmd_t mk_cmd(op_t op, int unsigned row, int unsigned row_end,
                                  int unsigned count, int unsigned value, int unsigned line);
    cmd_t c;
    c.op = op;
    c.row = rdlm_pkg::cnt_t'(row);
    c.row_end = rdlm_pkg::cnt_t'(row_end);
    c.count = rdlm_pkg::cnt_t'(count);
    c.value = rdlm_pkg::hgt_t'(value);
    c.line = rdlm_pkg::line_t'(line);
    return c;
  endfunction

  // random command shaped by the current table size
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int unsigned k = $urandom_range(0, 99);
    int unsigned span = row_count + 2;
    c.row = rdlm_pkg::cnt_t'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
                                                           : $urandom_range(0, span));
    c.row_end = rdlm_pkg::cnt_t'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
                                  : c.row + $urandom_range(0, 6) - 2);
    c.count = rdlm_pkg::cnt_t'(($urandom_range(0, 31) == 0) ? $urandom_range(0, 2047)
                                                             : $urandom_range(0, 6));
    c.value = rdlm_pkg::hgt_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 9));
    c.line = rdlm_pkg::line_t'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 262143)
                                : $urandom_range(0, line_start[row_count] + 3));
    if (k < 3) begin
      c.op = rdlm_pkg::OP_RESET;
      c.row = rdlm_pkg::cnt_t'($urandom_range(0, 40));
    end else if (k < 15) c.op = row_count > 200 ? rdlm_pkg::OP_REMOVE : rdlm_pkg::OP_INSERT;
    else if (k < 22) c.op = rdlm_pkg::OP_REMOVE;
    else if (k < 36) c.op = rdlm_pkg::OP_SET_HEIGHT;
    else if (k < 48) c.op = rdlm_pkg::OP_SET_VISIBLE;
    else if (k < 54) c.op = rdlm_pkg::OP_SET_EXPANDED;
    else if (k < 56) c.op = rdlm_pkg::OP_SHOW_ALL;
    else if (k < 58) c.op = rdlm_pkg::OP_FORGET;
    else if (k < 98) c.op = op_t'($urandom_range(rdlm_pkg::OP_QUERY_ROW, rdlm_pkg::OP_PREV_VIS));
    else c.op = OP_UNUSED;
    // keep the table small so that edits stay short
    if (row_count > 200 && c.op == rdlm_pkg::OP_REMOVE)
      c.count = rdlm_pkg::cnt_t'($urandom_range(100, 2047));
    return c;
  endfunction

  task automatic wait_drained();
    while (cmd_q.size() != 0 || start_i || answer_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_RESET, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_NEXT_VIS, 0, 0, 0, 0, 0));           // empty table
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_ROW_FROM_LINE, 0, 0, 0, 0, 5));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_DISP_LAST, 3, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_RESET, 2047, 0, 0, 0, 0));     // clamped row count
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_INSERT, 2047, 0, 2047, 0, 0)); // full table
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_REMOVE, 2, 0, 2047, 0, 0));    // remove past the end
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_INSERT, 1, 0, 6, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_SET_HEIGHT, 0, 0, 0, 255, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_SET_HEIGHT, 1, 0, 0, 0, 0));   // height zero ignored
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_SET_VISIBLE, 2, 1, 0, 0, 0));  // empty range
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_SET_VISIBLE, 5, 2047, 0, 0, 0)); // hide the tail
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_SET_HEIGHT, 6, 0, 0, 7, 0));   // hidden row
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_SET_EXPANDED, 3, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_SET_EXPANDED, 2047, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_QUERY_ROW, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_QUERY_ROW, 2047, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_DISP_FIRST, 2047, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_ROW_FROM_LINE, 0, 0, 0, 0, 262143)); // line past end
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_ROW_FROM_LINE, 0, 0, 0, 0, 100));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_CONTR_NEXT, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_NEXT_VIS, 7, 0, 0, 0, 0));     // searches backwards
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_PREV_VIS, 2047, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_FORGET, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(rdlm_pkg::OP_SHOW_ALL, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk_cmd(OP_UNUSED, 2047, 2047, 2047, 255, 262143));
    for (int k = cmd_q.size(); k < NUM_ITEMS; k++) begin
      // random commands are built against the table as it stands now
      while (cmd_q.size() > 1) @(posedge clk_i);
      if (k == NUM_ITEMS / 2) wait_drained();
      if (k == NUM_ITEMS - CALM_TAIL) idle_ok = 1'b0;
      cmd_q.push_back(rand_cmd());
    end
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (!failed) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  // reset held low from time zero, released on a falling edge
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // driver: one command transaction at a time, random gaps between them
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    cmd_t c;
    if (rst_ni) begin
      if (start_i && !taken) begin
        // still waiting for busy_o to drop
      end else if (gap > 0) begin
        gap--;
        start_i <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        c = cmd_q.pop_front();
        op_i <= c.op;
        row_i <= c.row;
        row_end_i <= c.row_end;
        count_i <= c.count;
        value_i <= c.value;
        line_i <= c.line;
        start_i <= 1'b1;
        if (idle_ok && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on acceptance, check every done strobe
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    answer_t want;
    taken = rst_ni && start_i && !busy_o;
    if (done_o && rst_ni) begin
      if (answer_q.size() == 0) begin
        $error("result with no command outstanding");
        failed = 1'b1;
      end else begin
        want = answer_q.pop_front();
        check_field("result_value", want.result_value, result_value_o);
        check_field("found", want.found, found_o);
        check_field("changed", want.changed, changed_o);
        check_field("sub_line", want.sub_line, sub_line_o);
        check_field("row_visible", want.row_visible, row_visible_o);
        check_field("row_expanded", want.row_expanded, row_expanded_o);
        check_field("overflow", want.overflow, overflow_o);
      end
    end
    if (taken)
      answer_q.push_back(apply_command(mk_cmd(op_i, row_i, row_end_i, count_i, value_i, line_i)));
    // watchdog on cycles with no transaction on either side
    if (taken || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    row_count = 0;
    clear_table();
  end

endmodule
